>>> hdl/rtwp_pkg.sv
// Package for the wideband power to decibel converter.
// Holds the shared widths, constants, the log2 table and the internal types.
// No dependencies; every other file in hdl/ imports it.
`default_nettype none

package rtwp_pkg;

  // Field widths.
  localparam int ANT_W   = 3;
  localparam int CAR_W   = 2;
  localparam int PWR_W   = 32;
  localparam int DB_W    = 12;
  localparam int LOG_W   = 22;   // log2 in unsigned Q16, up to 32.0
  localparam int PROD_W  = 47;   // log2 times the dB coefficient, Q32
  localparam int TENTH_W = 17;   // magnitude in units of one hundredth of a dB
  localparam int QUOT_W  = 14;

  // Radio kinds selected by the configuration register.
  typedef enum logic {
    RADIO_SUB6 = 1'b0,
    RADIO_MMW  = 1'b1
  } radio_kind_t;

  // round(65536 * 1000 * log10(2)).
  localparam logic [24:0] COEF_Q16 = 25'd19728302;

  // round(65536 * (1000 * log10(ref) + 100 * offset)) for each radio kind.
  localparam logic [32:0] K_SUB6_Q16 = 33'd744268531;
  localparam logic [32:0] K_MMW_Q16  = 33'd792801425;

  // Half of one tenth of a dB in Q16 hundredths, for rounding.
  localparam logic [32:0] HALF_TENTH_Q16 = 33'd327680;

  // Reciprocal of ten in Q19; exact for quotients of values below 2^18.
  localparam logic [15:0] RECIP10_Q19 = 16'd52429;
  localparam int          RECIP10_SH  = 19;

  // Fixed levels for a zero reading.
  localparam logic signed [DB_W-1:0] FLOOR_SUB6 = -12'sd1434;
  localparam logic signed [DB_W-1:0] FLOOR_MMW  = -12'sd1726;

  // Saturation limits of the output field.
  localparam logic [QUOT_W-1:0] MAX_POS_Q = 14'd2047;
  localparam logic [QUOT_W-1:0] MAX_NEG_Q = 14'd2048;
  localparam logic signed [DB_W-1:0] DB_MAX = 12'sh7FF;
  localparam logic signed [DB_W-1:0] DB_MIN = -12'sh800;

  // round(65536 * log2(1 + i/32)) for i = 0 .. 32.
  localparam logic [16:0] LOG2_TAB [33] = '{
    17'd0,     17'd2909,  17'd5732,  17'd8473,  17'd11136, 17'd13727,
    17'd16248, 17'd18704, 17'd21098, 17'd23433, 17'd25711, 17'd27936,
    17'd30109, 17'd32234, 17'd34312, 17'd36346, 17'd38336, 17'd40286,
    17'd42196, 17'd44068, 17'd45904, 17'd47705, 17'd49472, 17'd51207,
    17'd52911, 17'd54584, 17'd56229, 17'd57845, 17'd59434, 17'd60997,
    17'd62534, 17'd64047, 17'd65536
  };

  // Beat passed from the log2 unit to the scaling unit.
  typedef struct packed {
    logic [ANT_W-1:0] antenna;
    logic [CAR_W-1:0] carrier;
    logic             zero;
    logic [LOG_W-1:0] log_q16;
  } rtwp_log_t;

endpackage

`default_nettype wire

>>> hdl/rtwp_channels.sv
// Channel interfaces of the power to decibel converter: reading input,
// level output and the radio kind configuration write.
// Depends on rtwp_pkg.
`default_nettype none

interface rtwp_in_if;
  import rtwp_pkg::*;

  logic             valid;
  logic             ready;
  logic [ANT_W-1:0] antenna;
  logic [CAR_W-1:0] carrier;
  logic [PWR_W-1:0] power_reading;

  modport source (output valid, output antenna, output carrier,
                  output power_reading, input ready);
  modport sink   (input valid, input antenna, input carrier,
                  input power_reading, output ready);
endinterface

interface rtwp_out_if;
  import rtwp_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ANT_W-1:0]       antenna_tag;
  logic [CAR_W-1:0]       carrier_tag;
  logic signed [DB_W-1:0] power_tenth_db;

  modport source (output valid, output antenna_tag, output carrier_tag,
                  output power_tenth_db, input ready);
  modport sink   (input valid, input antenna_tag, input carrier_tag,
                  input power_tenth_db, output ready);
endinterface

interface rtwp_cfg_if;
  logic valid;
  logic ready;
  logic radio_kind;

  modport source (output valid, output radio_kind, input ready);
  modport sink   (input valid, input radio_kind, output ready);
endinterface

`default_nettype wire

>>> hdl/rtwp_log2.sv
// Two-stage log2 unit: leading-one search and table lookup, then linear
// interpolation into an unsigned Q16 logarithm.
// Depends on rtwp_pkg and rtwp_in_if.
`default_nettype none

module rtwp_log2 (
  input  wire logic               clk,
  input  wire logic               rst,
  rtwp_in_if.sink                 reading,
  output logic                    log_valid,
  input  wire logic               log_ready,
  output rtwp_pkg::rtwp_log_t     log_item
);
  import rtwp_pkg::*;

  // Stage 1 registers.
  logic             s1_valid;
  logic [ANT_W-1:0] s1_antenna;
  logic [CAR_W-1:0] s1_carrier;
  logic             s1_zero;
  logic [4:0]       s1_n;
  logic [16:0]      s1_lo;
  logic [11:0]      s1_step;
  logic [25:0]      s1_rem;

  logic             s1_ready;
  logic             s2_ready;

  logic [4:0]       lead;
  logic [PWR_W-1:0] norm;
  logic [4:0]       idx;
  logic [16:0]      tab_lo;
  logic [16:0]      tab_hi;

  logic [37:0]      interp_prod;
  logic [16:0]      interp;
  logic [LOG_W-1:0] log_next;

  // A stage takes a beat when it is empty or its contents move on.
  assign s2_ready      = !log_valid || log_ready;
  assign s1_ready      = !s1_valid || s2_ready;
  assign reading.ready = s1_ready;

  // Leading-one position, normalization and table lookup.
  always_comb begin
    lead = '0;
    for (int i = 0; i < PWR_W; i++) begin
      if (reading.power_reading[i]) begin
        lead = 5'(i);
      end
    end
    norm   = reading.power_reading << (5'd31 - lead);
    idx    = norm[30:26];
    tab_lo = LOG2_TAB[{1'b0, idx}];
    tab_hi = LOG2_TAB[{1'b0, idx} + 6'd1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= reading.valid;
    end
    if (s1_ready && reading.valid) begin
      s1_antenna <= reading.antenna;
      s1_carrier <= reading.carrier;
      s1_zero    <= (reading.power_reading == '0);
      s1_n       <= lead;
      s1_lo      <= tab_lo;
      s1_step    <= 12'(tab_hi - tab_lo);
      s1_rem     <= norm[25:0];
    end
  end

  // Interpolation between table points, rounded half up.
  always_comb begin
    interp_prod = 38'(s1_step) * 38'(s1_rem) + (38'd1 << 25);
    interp      = s1_lo + 17'(interp_prod[37:26]);
    log_next    = 22'({s1_n, 16'h0000}) + 22'(interp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      log_valid <= 1'b0;
    end else if (s2_ready) begin
      log_valid <= s1_valid;
    end
    if (s2_ready && s1_valid) begin
      log_item.antenna <= s1_antenna;
      log_item.carrier <= s1_carrier;
      log_item.zero    <= s1_zero;
      log_item.log_q16 <= log_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/rtwp_scale.sv
// Three-stage scaling unit: multiplies the log2 by the dB coefficient,
// removes the reference and offset, then rounds to tenths and saturates.
// Depends on rtwp_pkg and rtwp_out_if.
`default_nettype none

module rtwp_scale (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire rtwp_pkg::radio_kind_t radio_kind,
  input  wire logic                  log_valid,
  output logic                       log_ready,
  input  wire rtwp_pkg::rtwp_log_t   log_item,
  rtwp_out_if.source                 level
);
  import rtwp_pkg::*;

  // Stage 3 registers: product of log2 and coefficient.
  logic              s3_valid;
  logic [ANT_W-1:0]  s3_antenna;
  logic [CAR_W-1:0]  s3_carrier;
  logic              s3_zero;
  logic [PROD_W-1:0] s3_prod;

  // Stage 4 registers: magnitude in units of one hundredth of a dB.
  logic               s4_valid;
  logic [ANT_W-1:0]   s4_antenna;
  logic [CAR_W-1:0]   s4_carrier;
  logic               s4_zero;
  logic               s4_neg;
  logic [TENTH_W-1:0] s4_mag;

  logic s3_ready;
  logic s4_ready;
  logic s5_ready;

  logic [47:0]        rounded;
  logic [31:0]        hundredths;
  logic signed [32:0] diff;
  logic               diff_neg;
  logic [31:0]        diff_mag;
  logic [32:0]        biased;

  logic [32:0]            quot_prod;
  logic [QUOT_W-1:0]      quot;
  logic signed [DB_W-1:0] db_next;

  assign s5_ready  = !level.valid || level.ready;
  assign s4_ready  = !s4_valid || s5_ready;
  assign s3_ready  = !s3_valid || s4_ready;
  assign log_ready = s3_ready;

  // Coefficient multiply.
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= log_valid;
    end
    if (s3_ready && log_valid) begin
      s3_antenna <= log_item.antenna;
      s3_carrier <= log_item.carrier;
      s3_zero    <= log_item.zero;
      s3_prod    <= PROD_W'(log_item.log_q16) * PROD_W'(COEF_Q16);
    end
  end

  // Round to Q16 hundredths, subtract the reference term, take the
  // magnitude and add half a tenth before dropping the fraction.
  always_comb begin
    rounded    = 48'(s3_prod) + 48'd32768;
    hundredths = rounded[47:16];
    diff       = $signed({1'b0, hundredths})
               - $signed((radio_kind == RADIO_MMW) ? K_MMW_Q16 : K_SUB6_Q16);
    diff_neg   = diff[32];
    diff_mag   = diff_neg ? 32'(-diff) : diff[31:0];
    biased     = 33'(diff_mag) + HALF_TENTH_Q16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_ready) begin
      s4_valid <= s3_valid;
    end
    if (s4_ready && s3_valid) begin
      s4_antenna <= s3_antenna;
      s4_carrier <= s3_carrier;
      s4_zero    <= s3_zero;
      s4_neg     <= diff_neg;
      s4_mag     <= biased[32:16];
    end
  end

  // Divide by ten through the reciprocal, restore the sign and saturate.
  always_comb begin
    quot_prod = 33'(s4_mag) * 33'(RECIP10_Q19);
    quot      = quot_prod[32:RECIP10_SH];
    if (s4_zero) begin
      db_next = (radio_kind == RADIO_MMW) ? FLOOR_MMW : FLOOR_SUB6;
    end else if (s4_neg) begin
      db_next = (quot > MAX_NEG_Q) ? DB_MIN : $signed(12'(14'd0 - quot));
    end else begin
      db_next = (quot > MAX_POS_Q) ? DB_MAX : $signed(12'(quot));
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      level.valid <= 1'b0;
    end else if (s5_ready) begin
      level.valid <= s4_valid;
    end
    if (s5_ready && s4_valid) begin
      level.antenna_tag    <= s4_antenna;
      level.carrier_tag    <= s4_carrier;
      level.power_tenth_db <= db_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/rtwp_power_to_decibel.sv
// Converts a 32-bit linear wideband power reading into a level in 0.1 dB
// steps, 10*log10(reading/ref) minus the radio offset, with the antenna and
// carrier tags carried along. One reading is accepted every clock cycle
// unless the output stalls, and goes through two stages of log2 (leading-one
// search with table lookup, then interpolation) and three of scaling
// (coefficient multiply, reference subtraction, divide by ten and saturate).
// Each stage holds its beat while the output is stalled, so bubbles close up
// and no beat is lost. The radio kind register picks the sub-6 or mmWave
// reference and offset; write it only while no reading is in flight.
// Depends on rtwp_pkg, the channel interfaces, rtwp_log2 and rtwp_scale.
`default_nettype none

module rtwp_power_to_decibel (
  input  wire logic clk,
  input  wire logic rst,
  rtwp_cfg_if.sink  cfg,
  rtwp_in_if.sink   reading,
  rtwp_out_if.source level
);
  import rtwp_pkg::*;

  radio_kind_t radio_kind;
  logic        log_valid;
  logic        log_ready;
  rtwp_log_t   log_item;

  // Radio kind register; a write beat is taken every cycle.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radio_kind <= RADIO_SUB6;
    end else if (cfg.valid) begin
      radio_kind <= radio_kind_t'(cfg.radio_kind);
    end
  end

  rtwp_log2 u_log2 (
    .clk       (clk),
    .rst       (rst),
    .reading   (reading),
    .log_valid (log_valid),
    .log_ready (log_ready),
    .log_item  (log_item)
  );

  rtwp_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .radio_kind (radio_kind),
    .log_valid  (log_valid),
    .log_ready  (log_ready),
    .log_item   (log_item),
    .level      (level)
  );

endmodule

`default_nettype wire

>>> tb/rtwp_power_to_decibel_tb.sv
// Self-checking testbench for the wideband power to decibel converter.
// Drives readings and radio kind writes, and checks every level beat
// against an in-bench predictor. Depends on rtwp_pkg and the channel interfaces.
`timescale 1ns / 100ps

module rtwp_power_to_decibel_tb;
  import rtwp_pkg::*;

  // Bench copies of the conversion constants.
  localparam longint unsigned DB_COEF_Q16  = 64'd19728302;
  localparam longint          SUB6_REF_Q16 = 64'sd744268531;
  localparam longint          MMW_REF_Q16  = 64'sd792801425;
  localparam longint          TENTH_Q16    = 64'sd655360;
  localparam longint          HALF_TENTH   = 64'sd327680;
  localparam int              ZERO_SUB6    = -1434;
  localparam int              ZERO_MMW     = -1726;
  localparam int              LEVEL_TOP    = 2047;
  localparam int              LEVEL_BOTTOM = -2048;
  localparam int              HOLD_OFF_LEN = 60;
  localparam int              STALL_LIMIT  = 2000;
  localparam int              TAIL_CYCLES  = 20;

  // round(65536 * log2(1 + i/32)) for i = 0 .. 32.
  localparam int unsigned SEGMENT_LOG2 [33] = '{
    0, 2909, 5732, 8473, 11136, 13727, 16248, 18704,
    21098, 23433, 25711, 27936, 30109, 32234, 34312, 36346,
    38336, 40286, 42196, 44068, 45904, 47705, 49472, 51207,
    52911, 54584, 56229, 57845, 59434, 60997, 62534, 64047,
    65536
  };

  typedef struct {
    logic [ANT_W-1:0] antenna;
    logic [CAR_W-1:0] carrier;
    logic [PWR_W-1:0] power;
  } reading_beat_t;

  typedef struct {
    logic [ANT_W-1:0]       antenna_tag;
    logic [CAR_W-1:0]       carrier_tag;
    logic signed [DB_W-1:0] tenth_db;
  } level_beat_t;

  logic clk;
  logic rst;

  rtwp_cfg_if cfg_ch ();
  rtwp_in_if  reading_ch ();
  rtwp_out_if level_ch ();

  rtwp_power_to_decibel u_top (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .reading (reading_ch),
    .level   (level_ch)
  );

  reading_beat_t pending_readings [$];
  level_beat_t   expected_levels [$];
  radio_kind_t   radio_kind_model;
  bit            reading_taken;
  int            error_count;
  int            idle_cycles;
  int            src_idle_pct;
  int            snk_idle_pct;
  int            hold_off_req;
  int            hold_off_seen;
  int            hold_off_left;

  // Level in tenths of a dB for one reading under the given radio kind.
  function automatic logic signed [DB_W-1:0] tenth_db_of(input logic [PWR_W-1:0] pwr,
                                                         input radio_kind_t kind);
    int               lead;
    int               seg;
    logic [31:0]      norm;
    logic [25:0]      rem;
    longint unsigned  step;
    longint unsigned  log_q16;
    longint           hundredths;
    longint           tenths;
    if (pwr == 0) begin
      tenths = (kind == RADIO_MMW) ? ZERO_MMW : ZERO_SUB6;
    end else begin
      // Leading one gives the integer part; the mantissa indexes the table.
      lead = 31;
      while (lead > 0 && !pwr[lead]) lead--;
      norm = pwr << (31 - lead);
      seg  = int'(norm[30:26]);
      rem  = norm[25:0];
      step = longint'(SEGMENT_LOG2[seg+1] - SEGMENT_LOG2[seg]);
      log_q16 = (longint'(lead) << 16) + longint'(SEGMENT_LOG2[seg])
                + ((step * rem + 64'd33554432) >> 26);
      hundredths = longint'((log_q16 * DB_COEF_Q16 + 64'd32768) >> 16);
      hundredths -= (kind == RADIO_MMW) ? MMW_REF_Q16 : SUB6_REF_Q16;
      // Round half away from zero to tenths.
      if (hundredths < 0)
        tenths = -((-hundredths + HALF_TENTH) / TENTH_Q16);
      else
        tenths = (hundredths + HALF_TENTH) / TENTH_Q16;
    end
    if (tenths < LEVEL_BOTTOM) tenths = LEVEL_BOTTOM;
    if (tenths > LEVEL_TOP) tenths = LEVEL_TOP;
    return tenths[DB_W-1:0];
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Reading driver: offers the next pending beat once the current one is taken.
  always @(negedge clk) begin
    reading_beat_t beat;
    if (rst) begin
      reading_ch.valid <= 1'b0;
    end else if (!reading_ch.valid || reading_taken) begin
      if (pending_readings.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        beat = pending_readings.pop_front();
        reading_ch.valid         <= 1'b1;
        reading_ch.antenna       <= beat.antenna;
        reading_ch.carrier       <= beat.carrier;
        reading_ch.power_reading <= beat.power;
      end else begin
        reading_ch.valid <= 1'b0;
      end
    end
  end

  // Level receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      level_ch.ready <= 1'b0;
    end else if (hold_off_left > 0) begin
      hold_off_left--;
      level_ch.ready <= 1'b0;
    end else if (hold_off_seen != hold_off_req) begin
      hold_off_seen = hold_off_req;
      hold_off_left = HOLD_OFF_LEN - 1;
      level_ch.ready <= 1'b0;
    end else begin
      level_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Monitor: tracks the register, predicts each accepted reading, checks
  // each level beat, and watches for a stalled run.
  always @(posedge clk) begin
    level_beat_t want;
    bit          moved;
    if (rst) begin
      radio_kind_model = RADIO_SUB6;
      reading_taken    = 1'b0;
      idle_cycles      = 0;
    end else begin
      moved = 1'b0;
      if (cfg_ch.valid && cfg_ch.ready) begin
        radio_kind_model = radio_kind_t'(cfg_ch.radio_kind);
        moved = 1'b1;
      end
      reading_taken = reading_ch.valid && reading_ch.ready;
      if (reading_taken) begin
        want.antenna_tag = reading_ch.antenna;
        want.carrier_tag = reading_ch.carrier;
        want.tenth_db    = tenth_db_of(reading_ch.power_reading, radio_kind_model);
        expected_levels.push_back(want);
        moved = 1'b1;
      end
      if (level_ch.valid && level_ch.ready) begin
        moved = 1'b1;
        if (expected_levels.size() == 0) begin
          $error("level beat with no reading waiting: antenna_tag %0d power_tenth_db %0d",
                 level_ch.antenna_tag, level_ch.power_tenth_db);
          error_count++;
        end else begin
          want = expected_levels.pop_front();
          if (level_ch.antenna_tag !== want.antenna_tag) begin
            $error("antenna_tag: expected %0d, got %0d", want.antenna_tag,
                   level_ch.antenna_tag);
            error_count++;
          end
          if (level_ch.carrier_tag !== want.carrier_tag) begin
            $error("carrier_tag: expected %0d, got %0d", want.carrier_tag,
                   level_ch.carrier_tag);
            error_count++;
          end
          if (level_ch.power_tenth_db !== want.tenth_db) begin
            $error("power_tenth_db: expected %0d, got %0d", want.tenth_db,
                   level_ch.power_tenth_db);
            error_count++;
          end
        end
      end
      // Count cycles with work outstanding and no beat moving.
      if (moved || (pending_readings.size() == 0 && !reading_ch.valid &&
                    expected_levels.size() == 0 && !cfg_ch.valid))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("rtwp_power_to_decibel regression: fail");
        $finish;
      end
    end
  end

  task automatic push_reading(input int ant, input int car, input logic [PWR_W-1:0] pwr);
    reading_beat_t beat;
    beat.antenna = ant[ANT_W-1:0];
    beat.carrier = car[CAR_W-1:0];
    beat.power   = pwr;
    pending_readings.push_back(beat);
  endtask

  // Edge readings: zero, smallest, largest, powers of two, the last table
  // segment, and values near each reference.
  task automatic push_edge_readings();
    push_reading(0, 0, 32'd0);
    push_reading(7, 3, 32'hFFFF_FFFF);
    push_reading(1, 1, 32'd1);
    push_reading(2, 2, 32'd2);
    push_reading(3, 3, 32'd3);
    push_reading(4, 0, 32'h8000_0000);
    push_reading(5, 1, 32'h7FFF_FFFF);
    push_reading(6, 2, 32'h0001_0000);
    push_reading(0, 3, 32'h0000_FFFF);
    push_reading(1, 0, 32'd508904767);
    push_reading(2, 1, 32'd3366586);
    push_reading(7, 0, 32'h5555_5555);
  endtask

  // Random readings spread over all magnitudes, with some zeros.
  task automatic push_random_readings(input int count);
    logic [PWR_W-1:0] pwr;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0:       pwr = '0;
        1:       pwr = $urandom_range(1, 16);
        2, 3, 4: pwr = $urandom() >> $urandom_range(0, 31);
        default: pwr = $urandom();
      endcase
      push_reading($urandom_range(0, 7), $urandom_range(0, 3), pwr);
    end
  endtask

  // Holds the sender back until every expected level beat has arrived.
  task automatic wait_for_drain();
    while (pending_readings.size() != 0 || reading_ch.valid || expected_levels.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_radio_kind(input radio_kind_t kind);
    @(negedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.radio_kind <= kind;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Stimulus and end of run.
  initial begin
    rst                      = 1'b1;
    error_count              = 0;
    idle_cycles              = 0;
    reading_taken            = 1'b0;
    radio_kind_model         = RADIO_SUB6;
    src_idle_pct             = 23;
    snk_idle_pct             = 23;
    hold_off_req             = 0;
    hold_off_seen            = 0;
    hold_off_left            = 0;
    reading_ch.valid         = 1'b0;
    reading_ch.antenna       = '0;
    reading_ch.carrier       = '0;
    reading_ch.power_reading = '0;
    level_ch.ready           = 1'b0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.radio_kind        = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Sub-6 constants straight out of reset.
    push_edge_readings();
    push_random_readings(110);
    wait_for_drain();

    // mmWave constants, with a long receiver hold-off so the pipe backs up.
    write_radio_kind(RADIO_MMW);
    push_edge_readings();
    push_random_readings(110);
    hold_off_req++;
    wait_for_drain();

    // Back to sub-6 at full rate with no idling on either side.
    write_radio_kind(RADIO_SUB6);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    push_random_readings(150);
    wait_for_drain();

    // mmWave again with random idling.
    write_radio_kind(RADIO_MMW);
    src_idle_pct = 23;
    snk_idle_pct = 23;
    push_random_readings(110);
    wait_for_drain();

    // Let any stray level beat show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("rtwp_power_to_decibel regression: pass");
    else
      $display("rtwp_power_to_decibel regression: fail");
    $finish;
  end

endmodule

>>> rtwp_power_to_decibel.f
hdl/rtwp_pkg.sv
hdl/rtwp_channels.sv
hdl/rtwp_log2.sv
hdl/rtwp_scale.sv
hdl/rtwp_power_to_decibel.sv
tb/rtwp_power_to_decibel_tb.sv
